### design/fmfd_pkg.sv
// Shared types and constants for the frame-matrix-from-direction/up/position block.
// Used by every module of the block; no dependencies.
package fmfd_pkg;

   localparam int VEC_W       = 31;     // signed width of a normalizer input component
   localparam int MAG_W       = 30;     // magnitude width (|v| <= 2^29)
   localparam int SUM_W       = 62;     // sum of three squared 30-bit magnitudes
   localparam int LEN_W       = 32;
   localparam int REM_W       = 48;
   localparam int QUO_W       = 15;
   localparam int AXIS_W      = 16;
   localparam int NORM_MSB    = 28;     // scaled max magnitude reaches at least 2^28
   localparam int ONE_Q14     = 16384;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic signed [23:0] dir_x;
      logic signed [23:0] dir_y;
      logic signed [23:0] dir_z;
      logic signed [23:0] up_x;
      logic signed [23:0] up_y;
      logic signed [23:0] up_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] xaxis_x;
      logic signed [15:0] xaxis_y;
      logic signed [15:0] xaxis_z;
      logic signed [15:0] yaxis_x;
      logic signed [15:0] yaxis_y;
      logic signed [15:0] yaxis_z;
      logic signed [15:0] zaxis_x;
      logic signed [15:0] zaxis_y;
      logic signed [15:0] zaxis_z;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_type;

endpackage

### design/fmfd_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, square root, three dividers.
// Depends on fmfd_pkg. Whole pipe advances on en; sideband rides along.
module fmfd_norm #(
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  logic signed [fmfd_pkg::VEC_W-1:0] in_vec [3],
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_vld,
   output logic signed [fmfd_pkg::AXIS_W-1:0] out_axis [3],
   output logic [SIDE_W-1:0]                 out_side
);
   import fmfd_pkg::*;

   localparam int SQ_N = SUM_W / 2;   // sqrt iterations, bit 2^60 down to 2^0

   // stage 0: magnitudes
   logic [MAG_W-1:0]  mag0_ff [3];
   logic [MAG_W-1:0]  or0_ff;
   logic [2:0]        neg0_ff;
   logic [SIDE_W-1:0] side0_ff;
   logic              vld0_ff;
   // stage 1: shift amount
   logic [MAG_W-1:0]  mag1_ff [3];
   logic [4:0]        k1_ff;
   logic [4:0]        k1_in;
   logic [2:0]        neg1_ff;
   logic              zero1_ff;
   logic [SIDE_W-1:0] side1_ff;
   logic              vld1_ff;
   // stage 2: scaled magnitudes
   logic [MAG_W-1:0]  mag2_ff [3];
   logic [2:0]        neg2_ff;
   logic              zero2_ff;
   logic [SIDE_W-1:0] side2_ff;
   logic              vld2_ff;
   // stage 3: squares
   logic [2*MAG_W-1:0] sq3_ff [3];
   logic [MAG_W-1:0]  mag3_ff [3];
   logic [2:0]        neg3_ff;
   logic              zero3_ff;
   logic [SIDE_W-1:0] side3_ff;
   logic              vld3_ff;
   // stage 4: sum
   logic [SUM_W-1:0]  sum4_ff;
   logic [MAG_W-1:0]  mag4_ff [3];
   logic [2:0]        neg4_ff;
   logic              zero4_ff;
   logic [SIDE_W-1:0] side4_ff;
   logic              vld4_ff;

   always_comb begin
      k1_in = 5'd0;
      for (int b = 0; b < NORM_MSB; b++) begin
         if (or0_ff[b]) begin
            k1_in = 5'(NORM_MSB - b);
         end
      end
      if (or0_ff[MAG_W-1:NORM_MSB] != '0) begin
         k1_in = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= in_vld;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg0_ff[i] <= in_vec[i][VEC_W-1];
            mag0_ff[i] <= in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
            mag1_ff[i] <= mag0_ff[i];
            mag2_ff[i] <= mag1_ff[i] << k1_ff;
            sq3_ff[i]  <= mag2_ff[i] * mag2_ff[i];
            mag3_ff[i] <= mag2_ff[i];
            mag4_ff[i] <= mag3_ff[i];
         end
         or0_ff   <= (in_vec[0][VEC_W-1] ? MAG_W'(-in_vec[0]) : MAG_W'(in_vec[0]))
                   | (in_vec[1][VEC_W-1] ? MAG_W'(-in_vec[1]) : MAG_W'(in_vec[1]))
                   | (in_vec[2][VEC_W-1] ? MAG_W'(-in_vec[2]) : MAG_W'(in_vec[2]));
         side0_ff <= in_side;
         k1_ff    <= k1_in;
         neg1_ff  <= neg0_ff;
         zero1_ff <= (or0_ff == '0);
         side1_ff <= side0_ff;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
         side2_ff <= side1_ff;
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
         side3_ff <= side2_ff;
         sum4_ff  <= SUM_W'(sq3_ff[0]) + SUM_W'(sq3_ff[1]) + SUM_W'(sq3_ff[2]);
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
         side4_ff <= side3_ff;
      end
   end

   // square root: one result bit per stage
   logic [SUM_W-1:0]  sqs_ff  [SQ_N+1];
   logic [SUM_W-1:0]  sqr_ff  [SQ_N+1];
   logic [MAG_W-1:0]  sqm_ff  [SQ_N+1][3];
   logic [2:0]        sqn_ff  [SQ_N+1];
   logic              sqz_ff  [SQ_N+1];
   logic [SIDE_W-1:0] sqd_ff  [SQ_N+1];
   logic              sqv_ff  [SQ_N+1];

   always_comb begin
      sqs_ff[0]    = sum4_ff;
      sqr_ff[0]    = '0;
      sqm_ff[0][0] = mag4_ff[0];
      sqm_ff[0][1] = mag4_ff[1];
      sqm_ff[0][2] = mag4_ff[2];
      sqn_ff[0]    = neg4_ff;
      sqz_ff[0]    = zero4_ff;
      sqd_ff[0]    = side4_ff;
      sqv_ff[0]    = vld4_ff;
   end

   for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * g);
      logic [SUM_W-1:0] t_in;
      logic [SUM_W-1:0] s_in;
      logic [SUM_W-1:0] r_in;
      always_comb begin
         t_in = sqr_ff[g] + BIT;
         if (sqs_ff[g] >= t_in) begin
            s_in = sqs_ff[g] - t_in;
            r_in = (sqr_ff[g] >> 1) + BIT;
         end else begin
            s_in = sqs_ff[g];
            r_in = sqr_ff[g] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[g+1] <= 1'b0;
         end else if (en) begin
            sqv_ff[g+1] <= sqv_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sqs_ff[g+1] <= s_in;
            sqr_ff[g+1] <= r_in;
            sqm_ff[g+1] <= sqm_ff[g];
            sqn_ff[g+1] <= sqn_ff[g];
            sqz_ff[g+1] <= sqz_ff[g];
            sqd_ff[g+1] <= sqd_ff[g];
         end
      end
   end

   // dividers: q = ((mag << 15) + len) / (2 len), one quotient bit per stage
   logic [LEN_W-1:0]  len;
   logic [REM_W-1:0]  dvr_ff [QUO_W+1][3];
   logic [QUO_W-1:0]  dvq_ff [QUO_W+1][3];
   logic [REM_W-1:0]  dvd_ff [QUO_W+1];
   logic [2:0]        dvn_ff [QUO_W+1];
   logic              dvz_ff [QUO_W+1];
   logic [SIDE_W-1:0] dvs_ff [QUO_W+1];
   logic              dvv_ff [QUO_W+1];

   assign len = sqr_ff[SQ_N][LEN_W-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvr_ff[0][i] = (REM_W'(sqm_ff[SQ_N][i]) << QUO_W) + REM_W'(len);
         dvq_ff[0][i] = '0;
      end
      dvd_ff[0] = REM_W'(len) << 1;
      dvn_ff[0] = sqn_ff[SQ_N];
      dvz_ff[0] = sqz_ff[SQ_N];
      dvs_ff[0] = sqd_ff[SQ_N];
      dvv_ff[0] = sqv_ff[SQ_N];
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      localparam int SH = QUO_W - 1 - g;
      logic [REM_W-1:0] r_in [3];
      logic [QUO_W-1:0] q_in [3];
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            r_in[i] = dvr_ff[g][i];
            q_in[i] = dvq_ff[g][i];
            if (dvr_ff[g][i] >= (dvd_ff[g] << SH)) begin
               r_in[i]     = dvr_ff[g][i] - (dvd_ff[g] << SH);
               q_in[i][SH] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvv_ff[g+1] <= 1'b0;
         end else if (en) begin
            dvv_ff[g+1] <= dvv_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dvr_ff[g+1] <= r_in;
            dvq_ff[g+1] <= q_in;
            dvd_ff[g+1] <= dvd_ff[g];
            dvn_ff[g+1] <= dvn_ff[g];
            dvz_ff[g+1] <= dvz_ff[g];
            dvs_ff[g+1] <= dvs_ff[g];
         end
      end
   end

   // sign, clamp and zero-vector handling
   logic signed [AXIS_W-1:0] axis_ff [3];
   logic [SIDE_W-1:0]        oside_ff;
   logic                     ovld_ff;
   logic [AXIS_W-1:0]        qc [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i] = (AXIS_W'(dvq_ff[QUO_W][i]) > AXIS_W'(ONE_Q14)) ? AXIS_W'(ONE_Q14)
               : AXIS_W'(dvq_ff[QUO_W][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= dvv_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dvz_ff[QUO_W]) begin
               axis_ff[i] <= '0;
            end else if (dvn_ff[QUO_W][i]) begin
               axis_ff[i] <= -$signed(qc[i]);
            end else begin
               axis_ff[i] <= $signed(qc[i]);
            end
         end
         oside_ff <= dvs_ff[QUO_W];
      end
   end

   assign out_vld  = ovld_ff;
   assign out_axis = axis_ff;
   assign out_side = oside_ff;

endmodule

### design/fmfd_front.sv
// Front end: accepts request beats into a short queue ahead of the back pipeline.
// Depends on fmfd_pkg.
module fmfd_front #(
   parameter int DEPTH = fmfd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  fmfd_pkg::req_type req_data,
   output logic              deq_vld,
   input  logic              deq_rdy,
   output fmfd_pkg::req_type deq_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   import fmfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign req_full = (cnt_ff == CNT_W'(DEPTH));
   assign deq_vld  = (cnt_ff != '0);
   assign push     = req_push && !req_full;
   assign pop      = deq_vld && deq_rdy;
   assign deq_data = mem_ff[rd_ff];
   assign level    = cnt_ff;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end

endmodule

### design/fmfd_back.sv
// Back end: normalizes direction and up, forms the cross product, normalizes it.
// Depends on fmfd_pkg and fmfd_norm. Pipeline advances whenever its output is free.
module fmfd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   output logic              in_rdy,
   input  fmfd_pkg::req_type in_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fmfd_pkg::rsp_type rsp_data,
   output logic              pair_ok
);
   import fmfd_pkg::*;

   localparam int AX3_W = 3 * AXIS_W;
   localparam int CR_SIDE_W = 2 * AX3_W + 96;

   logic en;
   logic out_vld;

   assign en        = !out_vld || rsp_pop;
   assign in_rdy    = en;
   assign rsp_empty = !out_vld;

   logic signed [VEC_W-1:0]  dir_v [3];
   logic signed [VEC_W-1:0]  up_v  [3];
   logic signed [AXIS_W-1:0] za [3];
   logic signed [AXIS_W-1:0] ya [3];
   logic [63:0]              dside;
   logic [31:0]              uside;
   logic                     dvld, uvld;

   assign dir_v[0] = VEC_W'(in_data.dir_x);
   assign dir_v[1] = VEC_W'(in_data.dir_y);
   assign dir_v[2] = VEC_W'(in_data.dir_z);
   assign up_v[0]  = VEC_W'(in_data.up_x);
   assign up_v[1]  = VEC_W'(in_data.up_y);
   assign up_v[2]  = VEC_W'(in_data.up_z);

   fmfd_norm #(.SIDE_W(64)) u_dir (
      .clock, .reset, .en,
      .in_vld   (in_vld),
      .in_vec   (dir_v),
      .in_side  ({in_data.pos_x, in_data.pos_y}),
      .out_vld  (dvld),
      .out_axis (za),
      .out_side (dside)
   );

   fmfd_norm #(.SIDE_W(32)) u_up (
      .clock, .reset, .en,
      .in_vld   (in_vld),
      .in_vec   (up_v),
      .in_side  (in_data.pos_z),
      .out_vld  (uvld),
      .out_axis (ya),
      .out_side (uside)
   );

   assign pair_ok = (dvld == uvld);

   // cross product Y x Z: products, then differences
   logic signed [2*AXIS_W-1:0] p_ff [6];
   logic [CR_SIDE_W-1:0]       ps_ff;
   logic                       pv_ff;
   logic signed [VEC_W-1:0]    c_ff [3];
   logic [CR_SIDE_W-1:0]       cs_ff;
   logic                       cv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         cv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= dvld;
         cv_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= ya[1] * za[2];
         p_ff[1] <= ya[2] * za[1];
         p_ff[2] <= ya[2] * za[0];
         p_ff[3] <= ya[0] * za[2];
         p_ff[4] <= ya[0] * za[1];
         p_ff[5] <= ya[1] * za[0];
         ps_ff   <= {ya[0], ya[1], ya[2], za[0], za[1], za[2], dside, uside};
         c_ff[0] <= VEC_W'(p_ff[0]) - VEC_W'(p_ff[1]);
         c_ff[1] <= VEC_W'(p_ff[2]) - VEC_W'(p_ff[3]);
         c_ff[2] <= VEC_W'(p_ff[4]) - VEC_W'(p_ff[5]);
         cs_ff   <= ps_ff;
      end
   end

   logic signed [AXIS_W-1:0] xa [3];
   logic [CR_SIDE_W-1:0]     xs;

   fmfd_norm #(.SIDE_W(CR_SIDE_W)) u_crs (
      .clock, .reset, .en,
      .in_vld   (cv_ff),
      .in_vec   (c_ff),
      .in_side  (cs_ff),
      .out_vld  (out_vld),
      .out_axis (xa),
      .out_side (xs)
   );

   always_comb begin
      rsp_data.xaxis_x = xa[0];
      rsp_data.xaxis_y = xa[1];
      rsp_data.xaxis_z = xa[2];
      {rsp_data.yaxis_x, rsp_data.yaxis_y, rsp_data.yaxis_z,
       rsp_data.zaxis_x, rsp_data.zaxis_y, rsp_data.zaxis_z,
       rsp_data.trans_x, rsp_data.trans_y, rsp_data.trans_z} = xs;
   end

endmodule

### design/frame_matrix_from_dir_up_pos.sv
// Top level of the frame-matrix-from-direction/up/position block.
// Depends on fmfd_pkg, fmfd_front and fmfd_back.
//
// Usage:
//   Request channel: drive req_data and raise req_push; the beat is taken on a
//   clock edge where req_full is low. Requests land in a small queue.
//   Response channel: while rsp_empty is low, rsp_data holds the oldest frame
//   (X/Y/Z axis rows in Q2.14 and the translation row); pop takes it.
//   One response per request, in order. Zero-length vectors give zero axes.
// Throughput: one beat per cycle, sustained while each response is popped as it appears.
// Pipeline: behind the request queue, two normalizer pipelines in series
//   (52 stages each: 5 front stages, 31 square-root stages, 15 divider stages,
//   one output stage) with two cross-product stages between them.
// Stall: when the response is not popped the whole back pipeline holds;
//   the queue keeps taking requests until it fills, then req_full rises.
// Reset: synchronous, active high; empties the queue and the pipeline.
//   No configuration, no state carried between items.
module frame_matrix_from_dir_up_pos #(
   parameter int QUEUE_DEPTH = fmfd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  fmfd_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fmfd_pkg::rsp_type rsp_data
);
   import fmfd_pkg::*;

   logic                               q_vld, q_rdy;
   req_type                            q_data;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level;
   logic                               pair_ok;

   fmfd_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset,
      .req_push, .req_full, .req_data,
      .deq_vld  (q_vld),
      .deq_rdy  (q_rdy),
      .deq_data (q_data),
      .level    (q_level)
   );

   fmfd_back u_back (
      .clock, .reset,
      .in_vld    (q_vld),
      .in_rdy    (q_rdy),
      .in_data   (q_data),
      .rsp_empty, .rsp_pop, .rsp_data,
      .pair_ok
   );

   a_level_max: assert property (@(posedge clock) disable iff (reset)
      q_level <= $bits(q_level)'(QUEUE_DEPTH))
      else $error("request queue over depth");

   a_pair: assert property (@(posedge clock) disable iff (reset) pair_ok)
      else $error("direction and up normalizers out of step");

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   a_zaxis_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.zaxis_x <= 16'sd16384) && (rsp_data.zaxis_x >= -16'sd16384))
      else $error("z axis out of range");

endmodule
